/* rtl/gpfa_pkg.sv */
`timescale 1ns / 1ps
package gpfa_pkg;

    localparam int POSITION_BITS = 32;
    localparam int POS_W = (POSITION_BITS > 32) ? 32 : POSITION_BITS;
    localparam int DIFF_W = POS_W + 1;
    localparam int MAG_W = POS_W;
    localparam int R2_W = 2 * MAG_W + 2;
    localparam int ROOT_W = 35;
    localparam int DIST_W = 36;
    localparam int CUBE_W = 3 * DIST_W;
    localparam int NUM_W = 2 * MAG_W + 48;
    localparam int QUO_W = NUM_W;
    localparam int CNT_W = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_CUBE1,
        S_CUBE2,
        S_DIV,
        S_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic cube1;
        logic cube2;
        logic div_init;
        logic div_step;
        logic acc;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic cube_done;
        logic div_done;
        logic last;
    } t_status;

endpackage

/* rtl/gravity_pair_force_accumulator_top.sv */
`timescale 1ns / 1ps
// Softened gravity pair accumulator. Each accepted word carries one target and source
// position pair and the source mass; the block adds separation times mass over the cubed
// softened distance to three saturating Q16.48 sums, cleared by first_source (tuser bit 0)
// and emitted by tlast. Each pair passes through a load step, the bit-serial square root,
// the cube (one step to add the softening length and six 12-bit digit multiply steps), the
// shared-counter restoring dividers (one quotient bit per cycle for each axis) and an
// accumulate step, plus an output hand-over when tlast is set.
module gravity_pair_force_accumulator_top
    import gpfa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // target_x, target_y, target_z, source_x, source_y, source_z, source_mass
    input  logic [223:0] s_axis_tdata,
    // first_source
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accel_x, accel_y, accel_z
    output logic [191:0] m_axis_tdata,
    // saturated
    output logic         m_axis_tuser
);

    logic [31:0] r_soft;
    t_cmd    w_cmd;
    t_status w_status;
    logic [63:0] w_ax, w_ay, w_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft <= '0;
        end else if (i_cfg_wr_en) begin
            r_soft <= i_cfg_wr_data;
        end
    end

    gpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gpfa_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_soft   (r_soft),
        .i_tx     (s_axis_tdata[31:0]),
        .i_ty     (s_axis_tdata[63:32]),
        .i_tz     (s_axis_tdata[95:64]),
        .i_sx     (s_axis_tdata[127:96]),
        .i_sy     (s_axis_tdata[159:128]),
        .i_sz     (s_axis_tdata[191:160]),
        .i_mass   (s_axis_tdata[223:192]),
        .i_first  (s_axis_tuser),
        .i_last   (s_axis_tlast),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_ax     (w_ax),
        .o_ay     (w_ay),
        .o_az     (w_az),
        .o_sat    (m_axis_tuser)
    );

    assign m_axis_tdata = {w_az, w_ay, w_ax};

endmodule

/* rtl/gpfa_ctrl.sv */
`timescale 1ns / 1ps
module gpfa_ctrl
    import gpfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_done) n_state = S_CUBE1;
            end
            S_CUBE1: begin
                o_cmd.cube1 = 1'b1;
                n_state = S_CUBE2;
            end
            S_CUBE2: begin
                o_cmd.cube2 = 1'b1;
                if (i_status.cube_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_status.last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/gpfa_datapath.sv */
`timescale 1ns / 1ps
module gpfa_datapath
    import gpfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_soft,
    input  logic [31:0] i_tx,
    input  logic [31:0] i_ty,
    input  logic [31:0] i_tz,
    input  logic [31:0] i_sx,
    input  logic [31:0] i_sy,
    input  logic [31:0] i_sz,
    input  logic [31:0] i_mass,
    input  logic        i_first,
    input  logic        i_last,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [63:0] o_ax,
    output logic [63:0] o_ay,
    output logic [63:0] o_az,
    output logic        o_sat
);

    localparam logic [63:0] MAXV = 64'h7FFF_FFFF_FFFF_FFFF;

    logic [MAG_W-1:0]  r_mag [3];
    logic [2:0]        r_neg;
    logic [31:0]       r_mass;
    logic              r_last;
    logic [R2_W-1:0]   r_r2;
    logic [ROOT_W-1:0] r_root;
    logic [5:0]        r_bit;
    logic [DIST_W-1:0] r_dist;
    logic [2*DIST_W-1:0] r_sq;
    logic [CUBE_W-1:0] r_cube;
    logic [2:0]        r_mcnt;
    // Three restoring dividers share one iteration counter.
    logic [NUM_W-1:0]  r_num [3];
    logic [CUBE_W:0]   r_rem [3];
    logic [QUO_W-1:0]  r_quo [3];
    logic [CNT_W-1:0]  r_cnt;
    logic [63:0]       r_sum [3];
    logic              r_clip;

    logic signed [DIFF_W-1:0] w_d [3];
    logic [POS_W-1:0] w_s [3];
    logic [POS_W-1:0] w_t [3];
    logic [ROOT_W-1:0] w_cand;
    logic [2*ROOT_W-1:0] w_csq;
    logic [63:0] w_term [3];
    logic [2:0]  w_tclip;
    logic [63:0] w_nsum [3];
    logic [2:0]  w_sclip;
    logic [11:0] w_digit;
    logic [4:0]  w_shift;
    logic [DIST_W+11:0]   w_pp_sq;
    logic [2*DIST_W+11:0] w_pp_cube;

    assign w_s[0] = i_sx[POS_W-1:0];
    assign w_s[1] = i_sy[POS_W-1:0];
    assign w_s[2] = i_sz[POS_W-1:0];
    assign w_t[0] = i_tx[POS_W-1:0];
    assign w_t[1] = i_ty[POS_W-1:0];
    assign w_t[2] = i_tz[POS_W-1:0];

    assign w_cand = r_root | (ROOT_W'(1) << r_bit);
    assign w_csq  = w_cand * w_cand;

    // The square and the cube are built from 12-bit digits of the distance,
    // three steps for the square and then three for the cube.
    always_comb begin
        unique case (r_mcnt)
            3'd0, 3'd3: begin
                w_digit = r_dist[11:0];
                w_shift = 5'd0;
            end
            3'd1, 3'd4: begin
                w_digit = r_dist[23:12];
                w_shift = 5'd12;
            end
            default: begin
                w_digit = r_dist[DIST_W-1:24];
                w_shift = 5'd24;
            end
        endcase
    end

    assign w_pp_sq   = r_dist * w_digit;
    assign w_pp_cube = r_sq * w_digit;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k] = DIFF_W'(signed'(w_s[k])) - DIFF_W'(signed'(w_t[k]));
            if (r_cube == '0) begin
                w_term[k] = '0;
                w_tclip[k] = 1'b0;
            end else if (r_quo[k] > QUO_W'(MAXV)) begin
                w_term[k] = r_neg[k] ? -MAXV : MAXV;
                w_tclip[k] = 1'b1;
            end else begin
                w_term[k] = r_neg[k] ? -r_quo[k][63:0] : r_quo[k][63:0];
                w_tclip[k] = 1'b0;
            end
            w_nsum[k] = r_sum[k] + w_term[k];
            w_sclip[k] = (r_sum[k][63] == w_term[k][63]) && (w_nsum[k][63] != r_sum[k][63]);
            if (w_sclip[k]) w_nsum[k] = r_sum[k][63] ? 64'h8000_0000_0000_0000 : MAXV;
        end
    end

    assign o_status.sqrt_done = (r_bit == '0);
    assign o_status.cube_done = (r_mcnt == 3'd5);
    assign o_status.div_done  = (r_cnt == CNT_W'(1));
    assign o_status.last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
            r_clip <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= w_d[k][DIFF_W-1];
                    r_mag[k] <= MAG_W'(w_d[k][DIFF_W-1] ? -w_d[k] : w_d[k]);
                end
                if (i_first) begin
                    for (int k = 0; k < 3; k++) r_sum[k] <= '0;
                    r_clip <= 1'b0;
                end
                r_mass <= i_mass;
                r_last <= i_last;
                r_root <= '0;
                r_bit  <= 6'd35;
                r_r2   <= '0;
            end
            if (i_cmd.sqrt_step) begin
                if (r_bit == 6'd35) begin
                    // Squares of the separation are formed on the first step.
                    r_r2 <= R2_W'(r_mag[0] * r_mag[0]) + R2_W'(r_mag[1] * r_mag[1])
                          + R2_W'(r_mag[2] * r_mag[2]);
                    r_bit <= 6'd34;
                end else begin
                    if (R2_W'(w_csq) <= r_r2 && w_csq[2*ROOT_W-1:R2_W] == '0)
                        r_root <= w_cand;
                    if (r_bit != '0) r_bit <= r_bit - 6'd1;
                end
            end
            if (i_cmd.cube1) begin
                r_dist <= DIST_W'(r_root) + DIST_W'(i_soft);
                r_sq   <= '0;
                r_cube <= '0;
                r_mcnt <= '0;
            end
            if (i_cmd.cube2) begin
                if (r_mcnt < 3'd3) begin
                    r_sq <= r_sq + ((2*DIST_W)'(w_pp_sq) << w_shift);
                end else begin
                    r_cube <= r_cube + (CUBE_W'(w_pp_cube) << w_shift);
                end
                r_mcnt <= r_mcnt + 3'd1;
            end
            if (i_cmd.div_init) begin
                for (int k = 0; k < 3; k++) begin
                    r_num[k] <= NUM_W'(r_mag[k] * r_mass) << 48;
                    r_rem[k] <= '0;
                    r_quo[k] <= '0;
                end
                r_cnt <= CNT_W'(NUM_W);
            end
            if (i_cmd.div_step) begin
                for (int k = 0; k < 3; k++) begin
                    logic [CUBE_W:0] t;
                    t = {r_rem[k][CUBE_W-1:0], r_num[k][NUM_W-1]};
                    r_num[k] <= r_num[k] << 1;
                    if (r_cube != '0 && t >= {1'b0, r_cube}) begin
                        r_rem[k] <= t - {1'b0, r_cube};
                        r_quo[k] <= {r_quo[k][QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem[k] <= t;
                        r_quo[k] <= {r_quo[k][QUO_W-2:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.acc) begin
                for (int k = 0; k < 3; k++) r_sum[k] <= w_nsum[k];
                if (|w_tclip || |w_sclip) r_clip <= 1'b1;
            end
        end
    end

    assign o_ax = r_sum[0];
    assign o_ay = r_sum[1];
    assign o_az = r_sum[2];
    assign o_sat = r_clip;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import gpfa_pkg::*;

    typedef struct {
        logic signed [31:0] tx, ty, tz, sx, sy, sz;
        logic [31:0]        mass;
        logic               first, last;
    } t_pair;

    typedef struct {
        logic [63:0] ax, ay, az;
        logic        sat;
    } t_accel;

    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [31:0]   i_cfg_wr_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [223:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          s_axis_tlast = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [191:0]  m_axis_tdata;
    logic          m_axis_tuser;

    gravity_pair_force_accumulator_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Model state: softening length, three running sums and the clip flag.
    logic [31:0]        soft_len = '0;
    logic signed [63:0] acc_x = '0, acc_y = '0, acc_z = '0;
    logic               clip_flag = 1'b0;

    t_accel accel_queue[$];
    int     mismatches = 0;
    int     burst_left = 0;
    int     rx_cycle = 0;

    function automatic logic [34:0] floor_root(logic [127:0] n);
        logic [34:0] r;
        logic [34:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (35'd1 << b);
            if (n >= 128'(c) * 128'(c)) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic signed [63:0] axis_term(logic signed [32:0] d,
                                                     logic [31:0] m, logic [127:0] cube);
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0]  mg;
        if (cube == 0) begin
            return 64'sd0;
        end
        num = (128'(d < 0 ? -d : d) * 128'(m)) << 48;
        q = num / cube;
        if (q > 128'(ACC_MAX)) begin
            clip_flag = 1'b1;
            mg = ACC_MAX;
        end else begin
            mg = q[63:0];
        end
        return d < 0 ? -$signed(mg) : $signed(mg);
    endfunction

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(ACC_MAX)) begin
            clip_flag = 1'b1;
            return ACC_MAX;
        end
        if (s < 65'(ACC_MIN)) begin
            clip_flag = 1'b1;
            return ACC_MIN;
        end
        return s[63:0];
    endfunction

    function automatic void predict_accel(t_pair p);
        logic signed [32:0] dx, dy, dz;
        logic [127:0]       r2, cube, soft_dist;
        logic signed [63:0] ex, ey, ez;
        t_accel             a;
        dx = 33'(p.sx) - 33'(p.tx);
        dy = 33'(p.sy) - 33'(p.ty);
        dz = 33'(p.sz) - 33'(p.tz);
        if (p.first) begin
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
            clip_flag = 1'b0;
        end
        r2 = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
        soft_dist = 128'(floor_root(r2)) + 128'(soft_len);
        cube = soft_dist * soft_dist * soft_dist;
        ex = axis_term(dx, p.mass, cube);
        ey = axis_term(dy, p.mass, cube);
        ez = axis_term(dz, p.mass, cube);
        acc_x = sat_sum(acc_x, ex);
        acc_y = sat_sum(acc_y, ey);
        acc_z = sat_sum(acc_z, ez);
        if (p.last) begin
            a.ax = acc_x;
            a.ay = acc_y;
            a.az = acc_z;
            a.sat = clip_flag;
            accel_queue.push_back(a);
        end
    endfunction

    // Sends one pair, idling between bursts, and predicts it once accepted.
    task automatic send_pair(t_pair p);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.mass, p.sz, p.sy, p.sx, p.tz, p.ty, p.tx};
        s_axis_tuser  <= p.first;
        s_axis_tlast  <= p.last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_accel(p);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic set_softening(logic [31:0] v);
        wait (accel_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        soft_len = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic t_pair make_pair(logic signed [31:0] tx, ty, tz, sx, sy, sz,
                                        logic [31:0] m, logic f, logic l);
        t_pair p;
        p.tx = tx; p.ty = ty; p.tz = tz;
        p.sx = sx; p.sy = sy; p.sz = sz;
        p.mass = m; p.first = f; p.last = l;
        return p;
    endfunction

    task automatic test_directed();
        // Coincident particles with no softening give a zero term.
        send_pair(make_pair(5, 6, 7, 5, 6, 7, 32'hFFFF_FFFF, 1'b1, 1'b1));
        // Extreme separation on every axis.
        send_pair(make_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'hFFFF_FFFF, 1'b1, 1'b1));
        send_pair(make_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                            32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 1'b1, 1'b1));
        // A unit distance with full mass overflows the term; two of them the sum.
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_pair(make_pair(0, 0, 0, 1, -1, 0, 32'hFFFF_FFFF, 1'b0, 1'b1));
        send_pair(make_pair(0, 0, 0, -1, 0, 0, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_pair(make_pair(0, 0, 0, -1, 0, 1, 32'hFFFF_FFFF, 1'b0, 1'b1));
        // Without a first pair the emitted sums carry on.
        send_pair(make_pair(0, 0, 0, 32'sh0100_0000, 0, 0, 32'h8000_0000, 1'b0, 1'b1));
        send_pair(make_pair(1, 2, 3, 32'sh0100_0003, 32'sh0000_1000, 3,
                            32'h0000_0001, 1'b1, 1'b0));
        send_pair(make_pair(-9, 0, 0, 32'sh0200_0000, 32'shFF00_0000, 32'sh0300_0000,
                            32'h1234_5678, 1'b0, 1'b0));
        send_pair(make_pair(0, 0, 0, 0, 0, 32'sh0000_0100, 32'hFFFF_FFFF, 1'b0, 1'b1));
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] c);
        case ($urandom_range(0, 3))
            0: return c + $signed(32'($urandom_range(0, 15)) - 32'sd8);
            1: return c + $signed(32'($urandom_range(0, 65535)) - 32'sd32768);
            2: return c + $signed($urandom() >>> $urandom_range(4, 20));
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic test_random_targets(int pairs);
        t_pair p;
        int    n, k;
        n = 0;
        while (n < pairs) begin
            if ($urandom_range(0, 9) == 0) begin
                // Noise: random flags on random content.
                p = make_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                send_pair(p);
                n++;
            end else begin
                p.tx = $urandom(); p.ty = $urandom(); p.tz = $urandom();
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++) begin
                    p.sx = near(p.tx); p.sy = near(p.ty); p.sz = near(p.tz);
                    p.mass  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom();
                    p.first = (i == 0);
                    p.last  = (i == k - 1);
                    send_pair(p);
                    n++;
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        m_axis_tready <= (rx_cycle % 300 < 100) ? 1'b1 : ($urandom_range(0, 2) == 0);
    end

    always @(posedge i_clk) begin
        t_accel e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (accel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result word %h", m_axis_tdata);
                end
            end else begin
                e = accel_queue.pop_front();
                if (m_axis_tdata !== {e.az, e.ay, e.ax} || m_axis_tuser !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected x=%h y=%h z=%h sat=%b", e.ax, e.ay,
                                 e.az, e.sat);
                        $display("          actual   x=%h y=%h z=%h sat=%b",
                                 m_axis_tdata[63:0], m_axis_tdata[127:64],
                                 m_axis_tdata[191:128], m_axis_tuser);
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_softening(32'd0);
        test_directed();
        test_random_targets(130);
        set_softening(32'hFFFF_FFFF);
        test_directed();
        test_random_targets(100);
        set_softening(32'd1);
        test_random_targets(130);
        set_softening(32'h0100_0000);
        test_random_targets(130);
        set_softening($urandom());
        test_random_targets(130);
        wait (accel_queue.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && accel_queue.size() == 0) begin
            $display("PASS gravity_pair_force_accumulator_top");
        end else begin
            $display("FAIL gravity_pair_force_accumulator_top");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL gravity_pair_force_accumulator_top");
        $finish;
    end

endmodule

/* gravity_pair_force_accumulator_top.f */
rtl/gpfa_pkg.sv
rtl/gpfa_ctrl.sv
rtl/gpfa_datapath.sv
rtl/gravity_pair_force_accumulator_top.sv
sim/testbench.sv
